### design/mcg_pkg.sv
// ============================================================================
// mcg_pkg: shared definitions for the metronome click generator
// Widths, register indexes, divider request/response types and the
// quarter-wave sine magnitude table.
// ============================================================================
`default_nettype none

package mcg_pkg;

    localparam int POSITION_BITS = 24;
    localparam int SINE_ENTRIES  = 256;
    localparam int SAMPLE_BITS   = 16;

    localparam int FRAC_BITS     = 24;
    localparam int POS_W         = POSITION_BITS + FRAC_BITS;
    localparam int NEW_POS_BITS  = 24;

    // Divider: the dividend must hold a position plus one interval.
    localparam int DIV_N         = POSITION_BITS + 1;
    localparam int DIV_D         = 16;
    localparam int DIV_CNT_BITS  = $clog2(DIV_N + 1);

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam int SINE_IDX_BITS = $clog2(SINE_ENTRIES);
    localparam int SINE_QUARTER  = SINE_ENTRIES / 4;
    localparam int SINE_J_BITS   = SINE_IDX_BITS - 1;

    localparam logic [15:0] AMP_FULL   = 16'd65535;
    localparam logic [15:0] AMP_NORMAL = 16'd45875;

    localparam logic [15:0] RST_TICKS_PER_QUARTER = 16'd480;
    localparam logic [6:0]  RST_SUBDIVISIONS      = 7'd4;
    localparam logic [31:0] RST_TICK_STEP         = 32'd365221;
    localparam logic [9:0]  RST_CLICK_LENGTH      = 10'd88;
    localparam logic [15:0] RST_ACCENT_STEP       = 16'd5201;
    localparam logic [15:0] RST_NORMAL_STEP       = 16'd3269;
    localparam logic [15:0] RST_DECAY_FACTOR      = 16'd59840;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ENABLE            = 3'd0,
        CFG_TICKS_PER_QUARTER = 3'd1,
        CFG_SUBDIVISIONS      = 3'd2,
        CFG_TICK_STEP         = 3'd3,
        CFG_CLICK_LENGTH      = 3'd4,
        CFG_ACCENT_STEP       = 3'd5,
        CFG_NORMAL_STEP       = 3'd6,
        CFG_DECAY_FACTOR      = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic             start;
        logic [DIV_N-1:0] dividend;
        logic [DIV_D-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [DIV_N-1:0] quotient;
        logic [DIV_D-1:0] remainder;
    } div_rsp_t;

    typedef logic [14:0] sine_mag_t;
    typedef sine_mag_t sine_tab_t [SINE_QUARTER + 1];

    // Odd polynomial approximation of a quarter sine wave, t in Q16.
    function automatic sine_mag_t quarter_sine(input longint t);
        longint t2;
        longint inner;
        longint mid;
        longint y;
        t2    = (t * t) >> 16;
        inner = 42047 - ((t2 * 4640) >> 16);
        mid   = 102944 - ((t2 * inner) >> 16);
        y     = (t * mid) >> 16;
        y     = (y + 1) >> 1;
        if (y > 32767)
        begin
            y = 32767;
        end
        return y[14:0];
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        for (int j = 0; j <= SINE_QUARTER; j++)
        begin
            tab[j] = quarter_sine(longint'(j) * (65536 / SINE_QUARTER));
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

### design/mcg_ifs.sv
// ============================================================================
// mcg_ifs: stream channels of the metronome click generator
// Frame input channel and click sample output channel, valid/ready.
// ============================================================================
`default_nettype none

interface mcg_frame_if;
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic [mcg_pkg::NEW_POS_BITS-1:0] new_position;

    modport source (output valid, output op, output new_position, input ready);
    modport sink   (input valid, input op, input new_position, output ready);
endinterface

interface mcg_click_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [mcg_pkg::SAMPLE_BITS-1:0] sample;
    logic                                   click_started;
    logic                                   is_accent;

    modport source (output valid, output sample, output click_started, output is_accent,
                    input ready);
    modport sink   (input valid, input sample, input click_started, input is_accent,
                    output ready);
endinterface

`default_nettype wire

### design/metronome_click_generator.sv
// Each frame runs its divisions in turn on the shared divider: the interval always, one
// for a relocate, two for a click tick and one for a position wrap. A frame with no
// sounding voice skips the envelope states S_ENV and S_ENVW. One frame is in work at a
// time; the next is accepted only after the result is loaded into the output register,
// where it may wait.
// Reset (rst_n, asynchronous) loads the register defaults and clears the control state.
// ============================================================================
// metronome_click_generator: top level
// Advances a fixed-point song position per audio frame and renders a decaying
// sine click on every click tick while enabled, accented on each quarter note.
// ============================================================================
`default_nettype none

module metronome_click_generator (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    mcg_frame_if.sink                                  frame,
    mcg_click_if.source                                click,
    input  wire logic                                  cfg_we,
    input  wire logic [mcg_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [mcg_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int PB = mcg_pkg::POSITION_BITS;
    localparam int PW = mcg_pkg::POS_W;
    localparam int DN = mcg_pkg::DIV_N;
    localparam int SB = mcg_pkg::SAMPLE_BITS;
    localparam int IB = mcg_pkg::SINE_IDX_BITS;
    localparam int JB = mcg_pkg::SINE_J_BITS;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_IVL    = 12'b0000_0000_0010,
        S_RELOC  = 12'b0000_0000_0100,
        S_CHECK  = 12'b0000_0000_1000,
        S_CLKQ   = 12'b0000_0001_0000,
        S_CLKG   = 12'b0000_0010_0000,
        S_SAMPLE = 12'b0000_0100_0000,
        S_ENV    = 12'b0000_1000_0000,
        S_ENVW   = 12'b0001_0000_0000,
        S_ADV    = 12'b0010_0000_0000,
        S_WRAP   = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } state_t;

    // Configuration registers
    logic        enable_reg;
    logic [15:0] ticks_per_quarter_reg;
    logic [6:0]  subdivisions_reg;
    logic [31:0] tick_step_reg;
    logic [9:0]  click_length_reg;
    logic [15:0] accent_step_reg;
    logic [15:0] normal_step_reg;
    logic [15:0] decay_factor_reg;

    // Sequencer and voice state
    state_t           state_reg, state_next;
    logic             op_reg, op_next;
    logic [15:0]      interval_reg, interval_next;
    logic [PW-1:0]    song_pos_reg, song_pos_next;
    logic [PB-1:0]    next_click_reg, next_click_next;
    logic             next_beyond_reg, next_beyond_next;
    logic             click_active_reg, click_active_next;
    logic             click_accent_reg, click_accent_next;
    logic [9:0]       click_age_reg, click_age_next;
    logic [15:0]      env_reg, env_next;
    logic [15:0]      phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [31:0]      prod_reg, prod_next;
    logic [SB-1:0]    res_sample_reg, res_sample_next;
    logic             res_started_reg, res_started_next;
    logic             res_accent_reg, res_accent_next;
    logic             out_valid_reg, out_valid_next;
    logic [SB-1:0]    out_sample_reg, out_sample_next;
    logic             out_started_reg, out_started_next;
    logic             out_accent_reg, out_accent_next;

    mcg_pkg::div_req_t div_req;
    mcg_pkg::div_rsp_t div_rsp;

    logic [6:0]       eff_subs;
    logic [PB-1:0]    pint;
    logic [15:0]      ivl_div;
    logic [DN-1:0]    sync_n;
    logic [DN-1:0]    click_n;
    logic [PW:0]      adv_sum;
    logic [9:0]       len;
    logic [9:0]       age_inc;
    logic [IB-1:0]    sine_k;
    logic [IB-3:0]    sine_low;
    logic [JB-1:0]    sine_j;
    mcg_pkg::sine_mag_t sine_mag;
    logic [15:0]      mul_a;
    logic [15:0]      mul_b;
    logic [31:0]      mul_p;
    logic [SB-2:0]    smp_mag;
    logic [SB-1:0]    smp_signed;

    mcg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Dividend for ceil(p / ivl): p + ivl - 1.
    function automatic logic [DN-1:0] ceil_arg(input logic [PB-1:0] p,
                                               input logic [15:0] ivl);
        return DN'(p) + DN'(ivl) - DN'(1);
    endfunction

    always_comb
    begin
        if (subdivisions_reg == 7'd0)
        begin
            eff_subs = 7'd1;
        end
        else if (subdivisions_reg > 7'd64)
        begin
            eff_subs = 7'd64;
        end
        else
        begin
            eff_subs = subdivisions_reg;
        end
    end

    assign pint     = song_pos_reg[PW-1:mcg_pkg::FRAC_BITS];
    assign ivl_div  = (div_rsp.quotient[15:0] == 16'd0) ? 16'd1 : div_rsp.quotient[15:0];
    assign sync_n   = ceil_arg(pint, interval_reg) - DN'(div_rsp.remainder);
    // (q + 1) * I written as the floor multiple of the position plus one interval.
    assign click_n  = DN'(pint) - DN'(div_rsp.remainder) + DN'(interval_reg);
    assign adv_sum  = {1'b0, song_pos_reg} + (PW + 1)'(tick_step_reg);
    assign len      = (click_length_reg == 10'd0) ? 10'd1 : click_length_reg;
    assign age_inc  = click_age_reg + 10'd1;

    // Phase is quantized to the table resolution, then folded into a quarter wave.
    assign sine_k   = phase_reg[15 -: IB];
    assign sine_low = sine_k[IB-3:0];
    assign sine_j   = sine_k[IB-2] ? (JB'(mcg_pkg::SINE_QUARTER) - JB'(sine_low))
                                   : JB'(sine_low);
    assign sine_mag = mcg_pkg::SINE_TAB[sine_j];

    // A 15-bit magnitude times a 16-bit envelope cannot exceed the sample range,
    // so the magnitude is taken from the product without saturation.
    assign smp_mag    = prod_reg[30 -: (SB - 1)];
    assign smp_signed = neg_reg ? (SB'(0) - {1'b0, smp_mag}) : {1'b0, smp_mag};

    // Shared multiplier: sample scaling, then envelope decay.
    always_comb
    begin
        if (state_reg == S_ENV)
        begin
            mul_a = env_reg;
            mul_b = decay_factor_reg;
        end
        else
        begin
            mul_a = {1'b0, sine_mag};
            mul_b = env_reg;
        end
    end
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        interval_next     = interval_reg;
        song_pos_next     = song_pos_reg;
        next_click_next   = next_click_reg;
        next_beyond_next  = next_beyond_reg;
        click_active_next = click_active_reg;
        click_accent_next = click_accent_reg;
        click_age_next    = click_age_reg;
        env_next          = env_reg;
        phase_next        = phase_reg;
        neg_next          = neg_reg;
        prod_next         = prod_reg;
        res_sample_next   = res_sample_reg;
        res_started_next  = res_started_reg;
        res_accent_next   = res_accent_reg;
        out_valid_next    = out_valid_reg;
        out_sample_next   = out_sample_reg;
        out_started_next  = out_started_reg;
        out_accent_next   = out_accent_reg;
        div_req.start     = 1'b0;
        div_req.dividend  = '0;
        div_req.divisor   = '0;

        if (out_valid_reg && click.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (frame.valid)
                begin
                    op_next          = frame.op;
                    res_started_next = 1'b0;
                    if (frame.op)
                    begin
                        song_pos_next = {PB'(frame.new_position),
                                         {mcg_pkg::FRAC_BITS{1'b0}}};
                    end
                    div_req.start    = 1'b1;
                    div_req.dividend = DN'(ticks_per_quarter_reg);
                    div_req.divisor  = mcg_pkg::DIV_D'(eff_subs);
                    state_next       = S_IVL;
                end
            end
            S_IVL:
            begin
                if (!div_rsp.busy)
                begin
                    interval_next = ivl_div;
                    if (op_reg)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = ceil_arg(pint, ivl_div);
                        div_req.divisor  = ivl_div;
                        state_next       = S_RELOC;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_RELOC:
            begin
                if (!div_rsp.busy)
                begin
                    next_beyond_next = sync_n[DN-1];
                    next_click_next  = sync_n[DN-1] ? '0 : sync_n[PB-1:0];
                    state_next       = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!next_beyond_reg && (pint >= next_click_reg))
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DN'(pint);
                    div_req.divisor  = interval_reg;
                    state_next       = S_CLKQ;
                end
                else
                begin
                    state_next = S_SAMPLE;
                end
            end
            S_CLKQ:
            begin
                if (!div_rsp.busy)
                begin
                    next_beyond_next = click_n[DN-1];
                    next_click_next  = click_n[DN-1] ? '0 : click_n[PB-1:0];
                    // Click index within its group decides the accent.
                    div_req.start    = 1'b1;
                    div_req.dividend = div_rsp.quotient;
                    div_req.divisor  = mcg_pkg::DIV_D'(eff_subs);
                    state_next       = S_CLKG;
                end
            end
            S_CLKG:
            begin
                if (!div_rsp.busy)
                begin
                    if (enable_reg)
                    begin
                        click_active_next = 1'b1;
                        click_accent_next = (div_rsp.remainder == '0);
                        click_age_next    = '0;
                        phase_next        = '0;
                        env_next          = (div_rsp.remainder == '0) ? mcg_pkg::AMP_FULL
                                                                      : mcg_pkg::AMP_NORMAL;
                        res_started_next  = 1'b1;
                    end
                    state_next = S_SAMPLE;
                end
            end
            S_SAMPLE:
            begin
                if (click_active_reg && enable_reg)
                begin
                    prod_next       = mul_p;
                    neg_next        = sine_k[IB-1];
                    res_accent_next = click_accent_reg;
                    state_next      = S_ENV;
                end
                else
                begin
                    click_active_next = 1'b0;
                    res_sample_next   = '0;
                    res_accent_next   = 1'b0;
                    state_next        = S_ADV;
                end
            end
            S_ENV:
            begin
                res_sample_next = smp_signed;
                prod_next       = mul_p;
                phase_next      = phase_reg + (click_accent_reg ? accent_step_reg
                                                                : normal_step_reg);
                click_age_next  = age_inc;
                if (age_inc >= len)
                begin
                    click_active_next = 1'b0;
                end
                state_next = S_ENVW;
            end
            S_ENVW:
            begin
                env_next   = prod_reg[31:16];
                state_next = S_ADV;
            end
            S_ADV:
            begin
                song_pos_next = adv_sum[PW-1:0];
                // A carry out of the position means it wrapped: resync the schedule.
                if (adv_sum[PW])
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = ceil_arg(adv_sum[PW-1:mcg_pkg::FRAC_BITS], interval_reg);
                    div_req.divisor  = interval_reg;
                    state_next       = S_WRAP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WRAP:
            begin
                if (!div_rsp.busy)
                begin
                    next_beyond_next = sync_n[DN-1];
                    next_click_next  = sync_n[DN-1] ? '0 : sync_n[PB-1:0];
                    state_next       = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || click.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_sample_next  = res_sample_reg;
                    out_started_next = res_started_reg;
                    out_accent_next  = res_accent_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= 1'b0;
            interval_reg     <= 16'd1;
            song_pos_reg     <= '0;
            next_click_reg   <= '0;
            next_beyond_reg  <= 1'b0;
            click_active_reg <= 1'b0;
            click_accent_reg <= 1'b0;
            click_age_reg    <= '0;
            env_reg          <= '0;
            phase_reg        <= '0;
            res_started_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            interval_reg     <= interval_next;
            song_pos_reg     <= song_pos_next;
            next_click_reg   <= next_click_next;
            next_beyond_reg  <= next_beyond_next;
            click_active_reg <= click_active_next;
            click_accent_reg <= click_accent_next;
            click_age_reg    <= click_age_next;
            env_reg          <= env_next;
            phase_reg        <= phase_next;
            res_started_reg  <= res_started_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg         <= neg_next;
        prod_reg        <= prod_next;
        res_sample_reg  <= res_sample_next;
        res_accent_reg  <= res_accent_next;
        out_sample_reg  <= out_sample_next;
        out_started_reg <= out_started_next;
        out_accent_reg  <= out_accent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg            <= 1'b0;
            ticks_per_quarter_reg <= mcg_pkg::RST_TICKS_PER_QUARTER;
            subdivisions_reg      <= mcg_pkg::RST_SUBDIVISIONS;
            tick_step_reg         <= mcg_pkg::RST_TICK_STEP;
            click_length_reg      <= mcg_pkg::RST_CLICK_LENGTH;
            accent_step_reg       <= mcg_pkg::RST_ACCENT_STEP;
            normal_step_reg       <= mcg_pkg::RST_NORMAL_STEP;
            decay_factor_reg      <= mcg_pkg::RST_DECAY_FACTOR;
        end
        else if (cfg_we)
        begin
            unique case (mcg_pkg::cfg_idx_t'(cfg_index))
                mcg_pkg::CFG_ENABLE:            enable_reg            <= cfg_data[0];
                mcg_pkg::CFG_TICKS_PER_QUARTER: ticks_per_quarter_reg <= cfg_data[15:0];
                mcg_pkg::CFG_SUBDIVISIONS:      subdivisions_reg      <= cfg_data[6:0];
                mcg_pkg::CFG_TICK_STEP:         tick_step_reg         <= cfg_data[31:0];
                mcg_pkg::CFG_CLICK_LENGTH:      click_length_reg      <= cfg_data[9:0];
                mcg_pkg::CFG_ACCENT_STEP:       accent_step_reg       <= cfg_data[15:0];
                mcg_pkg::CFG_NORMAL_STEP:       normal_step_reg       <= cfg_data[15:0];
                mcg_pkg::CFG_DECAY_FACTOR:      decay_factor_reg      <= cfg_data[15:0];
            endcase
        end
    end

    assign frame.ready         = (state_reg == S_IDLE);
    assign click.valid         = out_valid_reg;
    assign click.sample        = out_sample_reg;
    assign click.click_started = out_started_reg;
    assign click.is_accent     = out_accent_reg;

    // The divider finishes every division before the frame completes.
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_rsp.busy)
        else $error("divider still busy while waiting for a frame");

    // A click tick past the position range parks the schedule at zero.
    a_beyond_zero: assert property (@(posedge clk) disable iff (!rst_n)
        next_beyond_reg |-> (next_click_reg == '0))
        else $error("next click tick not cleared while beyond the range");

    // A new result is loaded only by the completion state.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("output register loaded outside the completion state");

endmodule

`default_nettype wire

### design/mcg_div.sv
// ============================================================================
// mcg_div: iterative restoring divider
// One quotient bit per cycle; busy falls after the last quotient bit.
// ============================================================================
`default_nettype none

module mcg_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mcg_pkg::div_req_t req,
    output mcg_pkg::div_rsp_t      rsp
);

    logic                             busy_reg, busy_next;
    logic [mcg_pkg::DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [mcg_pkg::DIV_D-1:0]        rem_reg, rem_next;
    logic [mcg_pkg::DIV_N-1:0]        quo_reg, quo_next;
    logic [mcg_pkg::DIV_D-1:0]        dvs_reg, dvs_next;

    logic [mcg_pkg::DIV_D:0]          trial;
    logic [mcg_pkg::DIV_D:0]          diff;
    logic                             ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[mcg_pkg::DIV_N-1]};
        ge        = (trial >= {1'b0, dvs_reg});
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = mcg_pkg::DIV_CNT_BITS'(mcg_pkg::DIV_N);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // The partial remainder always stays below the divisor.
            rem_next  = ge ? diff[mcg_pkg::DIV_D-1:0] : trial[mcg_pkg::DIV_D-1:0];
            quo_next  = {quo_reg[mcg_pkg::DIV_N-2:0], ge};
            cnt_next  = cnt_reg - mcg_pkg::DIV_CNT_BITS'(1);
            busy_next = (cnt_reg != mcg_pkg::DIV_CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire
